### design/dphpr_pkg.sv
// ----------------------------------------------------------------------------
// dphpr_pkg: shared types and constants of the drum pad hit poll responder
// Holds command bytes, register indexes, pad note resets and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package dphpr_pkg;

  // Pad slots that have a note register; the active pad count is at most this
  localparam int unsigned PAD_SLOTS     = 6;
  localparam int unsigned PAD_COUNT_DEF = 6;

  // Field widths
  localparam int unsigned NOTE_W = 7;
  localparam int unsigned VEL_W  = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned CNT_W  = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD0_NOTE    = 3'd1;

  // Host command bytes and MIDI status
  localparam logic [BYTE_W-1:0] CMD_POLL       = 8'hAA;
  localparam logic [BYTE_W-1:0] CMD_FETCH      = 8'h55;
  localparam logic [BYTE_W-1:0] STATUS_NOTE_ON = 8'h90;

  // Reset values
  localparam logic [CHAN_W-1:0] MIDI_CHANNEL_RST = 4'd9;
  localparam logic [NOTE_W-1:0] PAD_NOTE_RST [PAD_SLOTS] =
    '{7'd45, 7'd38, 7'd46, 7'd48, 7'd49, 7'd36};

  // Action codes
  localparam logic ACT_NOTE_ON = 1'b0;
  localparam logic ACT_HOST    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT,
    ST_FETCH
  } dphpr_state_e;

  // Byte position inside one three-byte note-on message
  typedef enum logic [1:0] {
    PH_STATUS,
    PH_NOTE,
    PH_VEL
  } dphpr_phase_e;

  typedef struct packed {
    logic note_store;
    logic scan_init;
    logic scan_step;
    logic emit_count;
    logic fetch_init;
    logic emit_msg;
    logic fetch_clear;
  } dphpr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_last;
    logic count_nz;
    logic msg_last;
    logic item_note;
    logic item_poll;
    logic item_fetch;
  } dphpr_sts_t;

endpackage

### design/dphpr_if.sv
// ----------------------------------------------------------------------------
// dphpr_if: request channels of the drum pad hit poll responder
// Input channel (note-on events and host bytes) and reply byte channel.
// ----------------------------------------------------------------------------
interface dphpr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [6:0] note_number;
  logic [6:0] hit_velocity;
  logic [7:0] host_byte;

  modport source (output valid, action, note_number, hit_velocity, host_byte,
                  input ready);
  modport sink   (input valid, action, note_number, hit_velocity, host_byte,
                  output ready);
endinterface

interface dphpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       last_byte;

  modport source (output valid, reply_byte, last_byte, input ready);
  modport sink   (input valid, reply_byte, last_byte, output ready);
endinterface

### design/dphpr_ctrl.sv
// ----------------------------------------------------------------------------
// dphpr_ctrl: sequencer of the drum pad hit poll responder
// Accepts requests in idle, walks the pads on a poll and walks the message
// buffer on a fetch, one output byte per free output slot.
// ----------------------------------------------------------------------------
module dphpr_ctrl import dphpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dphpr_sts_t sts_i,
  output dphpr_cmd_t cmd_o
);

  dphpr_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.item_note) begin
            cmd_o.note_store = 1'b1;
          end else if (sts_i.item_poll) begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_SCAN;
          end else if (sts_i.item_fetch && sts_i.count_nz) begin
            cmd_o.fetch_init = 1'b1;
            state_d          = ST_FETCH;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_count = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_FETCH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_msg = 1'b1;
          if (sts_i.msg_last) begin
            cmd_o.fetch_clear = 1'b1;
            state_d           = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/dphpr_datapath.sv
// ----------------------------------------------------------------------------
// dphpr_datapath: storage and byte path of the drum pad hit poll responder
// Configuration registers, pending velocities, message buffer, counters
// and the output byte register.
// ----------------------------------------------------------------------------
module dphpr_datapath import dphpr_pkg::*; #(
  parameter int unsigned PadCount = PAD_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_action_i,
  input  logic [NOTE_W-1:0]     in_note_i,
  input  logic [VEL_W-1:0]      in_vel_i,
  input  logic [BYTE_W-1:0]     in_host_i,
  input  dphpr_cmd_t            cmd_i,
  output dphpr_sts_t            sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [BYTE_W-1:0]     out_byte_o,
  output logic                  out_last_o
);

  localparam int unsigned IdxW = (PadCount > 1) ? $clog2(PadCount) : 1;

  logic [CHAN_W-1:0] chan_q;
  logic [NOTE_W-1:0] pad_note_q   [PAD_SLOTS];
  logic [NOTE_W-1:0] pad_note_use [PadCount];
  logic [VEL_W-1:0]  pend_q       [PadCount];
  logic [NOTE_W-1:0] buf_note_q   [PadCount];
  logic [VEL_W-1:0]  buf_vel_q    [PadCount];

  logic [IdxW-1:0]  scan_idx_q;
  logic [IdxW-1:0]  ent_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] cnt_q;
  dphpr_phase_e     phase_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;

  logic              hit;
  logic [IdxW-1:0]   hit_idx;
  logic [VEL_W-1:0]  pend_cur;
  logic              pend_nz;
  logic              scan_last;
  logic              ent_last;
  logic              msg_last;
  logic              out_free;
  logic [BYTE_W-1:0] msg_byte;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= MIDI_CHANNEL_RST;
      for (int i = 0; i < PAD_SLOTS; i++) begin
        pad_note_q[i] <= PAD_NOTE_RST[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MIDI_CHANNEL) begin
        chan_q <= cfg_wdata_i[CHAN_W-1:0];
      end
      for (int i = 0; i < PAD_SLOTS; i++) begin
        if (cfg_idx_i == CFG_PAD0_NOTE + CFG_IDX_W'(i)) begin
          pad_note_q[i] <= cfg_wdata_i[NOTE_W-1:0];
        end
      end
    end
  end

  // Only the active pads take part in matching and polling
  for (genvar g = 0; g < PadCount; g++) begin : g_pad_use
    assign pad_note_use[g] = pad_note_q[g];
  end

  // Note match: lowest pad wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = PadCount - 1; i >= 0; i--) begin
      if (pad_note_use[i] == in_note_i) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  assign pend_cur  = pend_q[scan_idx_q];
  assign pend_nz   = (pend_cur != '0);
  assign scan_last = (scan_idx_q == IdxW'(PadCount - 1));

  // Pending velocities
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PadCount; i++) begin
        pend_q[i] <= '0;
      end
    end else begin
      if (cmd_i.note_store && hit) begin
        pend_q[hit_idx] <= in_vel_i;
      end
      if (cmd_i.scan_step && pend_nz) begin
        pend_q[scan_idx_q] <= '0;
      end
    end
  end

  // Message buffer, written at the pack pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && pend_nz) begin
      buf_note_q[n_q[IdxW-1:0]] <= pad_note_use[scan_idx_q];
      buf_vel_q[n_q[IdxW-1:0]]  <= pend_cur;
    end
  end

  // Scan, pack and fetch counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      n_q        <= '0;
      cnt_q      <= '0;
      ent_q      <= '0;
      phase_q    <= PH_STATUS;
    end else begin
      if (cmd_i.scan_init) begin
        scan_idx_q <= '0;
        n_q        <= '0;
      end else if (cmd_i.scan_step) begin
        if (!scan_last) begin
          scan_idx_q <= scan_idx_q + IdxW'(1);
        end
        if (pend_nz) begin
          n_q <= n_q + CNT_W'(1);
        end
      end

      if (cmd_i.emit_count) begin
        cnt_q <= n_q;
      end else if (cmd_i.fetch_clear) begin
        cnt_q <= '0;
      end

      if (cmd_i.fetch_init) begin
        ent_q   <= '0;
        phase_q <= PH_STATUS;
      end else if (cmd_i.emit_msg) begin
        case (phase_q)
          PH_STATUS: phase_q <= PH_NOTE;
          PH_NOTE:   phase_q <= PH_VEL;
          PH_VEL: begin
            phase_q <= PH_STATUS;
            if (!ent_last) begin
              ent_q <= ent_q + IdxW'(1);
            end
          end
          default: phase_q <= PH_STATUS;
        endcase
      end
    end
  end

  // Current message byte
  assign ent_last = (CNT_W'(ent_q) == cnt_q - CNT_W'(1));
  assign msg_last = ent_last && (phase_q == PH_VEL);

  always_comb begin
    case (phase_q)
      PH_STATUS: msg_byte = STATUS_NOTE_ON | BYTE_W'(chan_q);
      PH_NOTE:   msg_byte = BYTE_W'(buf_note_q[ent_q]);
      PH_VEL:    msg_byte = BYTE_W'(buf_vel_q[ent_q]);
      default:   msg_byte = '0;
    endcase
  end

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_count || cmd_i.emit_msg) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_count) begin
      out_byte_q <= BYTE_W'(n_q);
      out_last_q <= 1'b1;
    end else if (cmd_i.emit_msg) begin
      out_byte_q <= msg_byte;
      out_last_q <= msg_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // Status to the sequencer
  always_comb begin
    sts_o            = '0;
    sts_o.out_free   = out_free;
    sts_o.scan_last  = scan_last;
    sts_o.count_nz   = (cnt_q != '0);
    sts_o.msg_last   = msg_last;
    sts_o.item_note  = (in_action_i == ACT_NOTE_ON);
    sts_o.item_poll  = (in_action_i == ACT_HOST) && (in_host_i == CMD_POLL);
    sts_o.item_fetch = (in_action_i == ACT_HOST) && (in_host_i == CMD_FETCH);
  end

endmodule

### design/drum_pad_hit_poll_responder.sv
// ----------------------------------------------------------------------------
// drum_pad_hit_poll_responder: pending drum hits answered to host polls
// Top level: sequencer, datapath, channel hookup and checks.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one request per handshake: a local note-on (action 0,
//   note_number, hit_velocity) or a host byte (action 1, host_byte).
//   out_if returns reply bytes; last_byte marks the end of each reply.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the MIDI channel (index 0) and the
//   pad notes (indexes 1 to 6); write only while the block is idle.
// Timing:
//   A note-on gives no reply.
//   A poll (0xAA) scans one pad per cycle, then loads the count byte
//   into the output register once the output slot is free.
//   A fetch (0x55) with count n sends 3*n bytes, one per cycle while
//   the output slot is free, paced by the single output register.
//   Other host bytes give no reply.
//   One request is worked at a time; a new one is taken as soon as the
//   last byte of the previous reply sits in the output register.
// Reset clears pending hits, the count and the output valid flag and loads
// the default channel and pad notes. A stalled receiver holds the output
// byte and the sequencer waits for the slot to free.
// ----------------------------------------------------------------------------
module drum_pad_hit_poll_responder import dphpr_pkg::*; #(
  parameter int unsigned PadCount = PAD_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dphpr_in_if.sink              in_if,
  dphpr_out_if.source           out_if
);

  dphpr_cmd_t cmd;
  dphpr_sts_t sts;
  logic       in_ready;

  assign in_if.ready = in_ready;

  // Sequencer
  dphpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and byte path
  dphpr_datapath #(
    .PadCount (PadCount)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_action_i (in_if.action),
    .in_note_i   (in_if.note_number),
    .in_vel_i    (in_if.hit_velocity),
    .in_host_i   (in_if.host_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_byte_o  (out_if.reply_byte),
    .out_last_o  (out_if.last_byte)
  );

  // A byte is only loaded into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_count || cmd.emit_msg) |-> sts.out_free)
    else $error("reply byte loaded over a waiting byte");

  // Count reply and message bytes never load together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.emit_count && cmd.emit_msg))
    else $error("two reply bytes loaded at once");

  // An accepted poll keeps the input closed while the pads are scanned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_ready && (in_if.action == ACT_HOST) &&
     (in_if.host_byte == CMD_POLL)) |=> !in_ready)
    else $error("request accepted during pad scan");

  // The last message byte clears the buffered count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fetch_clear |=> !sts.count_nz)
    else $error("count not cleared after fetch");

endmodule
